// File: hw/rtl/camimp_pkg.sv
package camimp_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ROT_ROW_X    = 3'd0;
   localparam logic [2:0] CSR_ROT_ROW_Y    = 3'd1;
   localparam logic [2:0] CSR_ROT_ROW_Z    = 3'd2;
   localparam logic [2:0] CSR_PLANE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_PLANE_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_PIXEL_WIDTH  = 3'd5;
   localparam logic [2:0] CSR_PIXEL_HEIGHT = 3'd6;
   localparam logic [2:0] CSR_INV_AREA     = 3'd7;

   localparam logic [47:0] ROT_ROW_X_RESET = 48'h0000_0000_1000;
   localparam logic [47:0] ROT_ROW_Y_RESET = 48'h0000_1000_0000;
   localparam logic [47:0] ROT_ROW_Z_RESET = 48'h1000_0000_0000;

   localparam int DIV_BITS    = 20;  // quotient bits of the projection divide
   localparam int SQRT_STEPS  = 30;  // root bits of the 60-bit radicand

   // One lane of the restoring divider.
   typedef struct packed {
      logic [57:0] rem;
      logic [40:0] den;
      logic [19:0] quo;
   } div_lane_type;

   // Item context that rides along with the divider.
   typedef struct packed {
      logic        func;
      logic        rejected;
      logic [28:0] mx_pix;
      logic [28:0] my_pix;
   } div_side_type;

   // One stage of the square root pipeline.
   typedef struct packed {
      logic [59:0] q;
      logic [29:0] root;
      logic [30:0] rem;
      logic        rejected;
   } sqrt_stage_type;

   function automatic div_lane_type div_step(input div_lane_type d, input logic [4:0] sh);
      logic [60:0]  dsh;
      div_lane_type r;
      dsh = 61'(d.den) << sh;
      r   = d;
      if (61'(d.rem) >= dsh) begin
         r.rem = d.rem - dsh[57:0];
         r.quo = {d.quo[18:0], 1'b1};
      end else begin
         r.quo = {d.quo[18:0], 1'b0};
      end
      return r;
   endfunction

   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s, input logic [1:0] pair);
      logic [32:0]    rem_n;
      logic [32:0]    trial;
      sqrt_stage_type r;
      rem_n = {s.rem, pair};
      trial = {1'b0, s.root, 2'b01};
      r     = s;
      if (rem_n >= trial) begin
         r.rem  = 31'(rem_n - trial);
         r.root = {s.root[28:0], 1'b1};
      end else begin
         r.rem  = rem_n[30:0];
         r.root = {s.root[28:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/camimp_div.sv
module camimp_div
   import camimp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         ce,
   input  logic         in_valid,
   input  div_lane_type in_x,
   input  div_lane_type in_y,
   input  div_side_type in_side,
   output logic         out_valid,
   output div_lane_type out_x,
   output div_lane_type out_y,
   output div_side_type out_side
);

   logic         v_ff    [0:DIV_BITS-1];
   div_lane_type x_ff    [0:DIV_BITS-1];
   div_lane_type y_ff    [0:DIV_BITS-1];
   div_side_type side_ff [0:DIV_BITS-1];
   div_lane_type x_in    [0:DIV_BITS-1];
   div_lane_type y_in    [0:DIV_BITS-1];

   // Stage i settles quotient bit DIV_BITS-1-i, most significant first.
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
      div_lane_type src_x;
      div_lane_type src_y;
      if (i == 0) begin : g_first
         assign src_x = in_x;
         assign src_y = in_y;
      end else begin : g_rest
         assign src_x = x_ff[i-1];
         assign src_y = y_ff[i-1];
      end
      assign x_in[i] = div_step(src_x, 5'(DIV_BITS - 1 - i));
      assign y_in[i] = div_step(src_y, 5'(DIV_BITS - 1 - i));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_BITS; i++) v_ff[i] <= 1'b0;
      end else if (ce) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < DIV_BITS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < DIV_BITS; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < DIV_BITS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
         end
      end
   end

   assign out_valid = v_ff[DIV_BITS-1];
   assign out_x     = x_ff[DIV_BITS-1];
   assign out_y     = y_ff[DIV_BITS-1];
   assign out_side  = side_ff[DIV_BITS-1];

endmodule

// File: hw/rtl/camimp_sqrt.sv
module camimp_sqrt
   import camimp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           ce,
   input  logic           in_valid,
   input  sqrt_stage_type in_data,
   output logic           out_valid,
   output sqrt_stage_type out_data
);

   logic           v_ff [0:SQRT_STEPS-1];
   sqrt_stage_type s_ff [0:SQRT_STEPS-1];
   sqrt_stage_type s_in [0:SQRT_STEPS-1];

   // Stage j brings down the j-th bit pair of the radicand, highest pair first.
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      sqrt_stage_type src;
      if (j == 0) begin : g_first
         assign src = in_data;
      end else begin : g_rest
         assign src = s_ff[j-1];
      end
      assign s_in[j] = sqrt_step(src, src.q[2*SQRT_STEPS-1-2*j -: 2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQRT_STEPS; j++) v_ff[j] <= 1'b0;
      end else if (ce) begin
         v_ff[0] <= in_valid;
         for (int j = 1; j < SQRT_STEPS; j++) v_ff[j] <= v_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int j = 0; j < SQRT_STEPS; j++) s_ff[j] <= s_in[j];
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign out_data  = s_ff[SQRT_STEPS-1];

endmodule

// File: hw/rtl/perspective_camera_importance_top.sv
// Pinhole camera importance, one result transaction for every request transaction.
// Request channel: req_tuser selects the mode (0 pixel position, 1 world direction),
// req_tdata carries pix_x, pix_y, dir_x, dir_y and dir_z. Response channel: rsp_tdata
// is the Q16.16 importance, rsp_tuser flags a rejected direction and a clamped value.
// The csr_ port writes one register per cycle with csr_we high; write it only while
// no transaction is in flight.
// The datapath is a single pipeline: four front stages for the products, the plane
// test and the projection set-up, a 20-stage restoring divider (one quotient bit per
// stage), two stages forming 1 + x^2 + y^2, a 30-stage square root (one root bit per
// stage) and four stages for the two split multiplies and saturation. Throughput is
// one transaction per cycle while the pipeline is not frozen by rsp_tready.
// Reset empties the pipeline and loads the identity rotation; the plane, pixel and
// area registers reset to zero.
// When the receiver holds rsp_tready low with a result waiting, the whole pipeline
// freezes and req_tready drops in the same cycle; nothing is lost or repeated.
module perspective_camera_importance_top
   import camimp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,   // pix_x[19:0], pix_y[39:20], dir_x[63:40],
                                      // dir_y[87:64], dir_z[111:88]
   input  logic          req_tuser,   // func[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // importance_value[31:0]
   output logic [1:0]    rsp_tuser,   // rejected[0], saturated[1]
   input  logic          csr_we,
   input  logic [2:0]    csr_addr,
   input  logic [47:0]   csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [47:0] rot_ff [0:2];
   logic [23:0] plane_width_ff, plane_height_ff;
   logic [31:0] pixel_width_ff, pixel_height_ff, inv_area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]       <= ROT_ROW_X_RESET;
         rot_ff[1]       <= ROT_ROW_Y_RESET;
         rot_ff[2]       <= ROT_ROW_Z_RESET;
         plane_width_ff  <= '0;
         plane_height_ff <= '0;
         pixel_width_ff  <= '0;
         pixel_height_ff <= '0;
         inv_area_ff     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ROT_ROW_X:    rot_ff[0]       <= csr_wdata;
            CSR_ROT_ROW_Y:    rot_ff[1]       <= csr_wdata;
            CSR_ROT_ROW_Z:    rot_ff[2]       <= csr_wdata;
            CSR_PLANE_WIDTH:  plane_width_ff  <= csr_wdata[23:0];
            CSR_PLANE_HEIGHT: plane_height_ff <= csr_wdata[23:0];
            CSR_PIXEL_WIDTH:  pixel_width_ff  <= csr_wdata[31:0];
            CSR_PIXEL_HEIGHT: pixel_height_ff <= csr_wdata[31:0];
            CSR_INV_AREA:     inv_area_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves unless a result is stuck at the output.
   logic ce;
   logic rsp_v_ff;
   assign ce         = !rsp_v_ff || rsp_tready;
   assign req_tready = ce;

   // ---------------- stage 1: products ----------------
   logic               st1_v_ff, st1_func_ff;
   logic [51:0]        st1_pxw_ff, st1_pyw_ff, st1_pxw_in, st1_pyw_in;
   logic signed [39:0] st1_prod_ff [0:8];
   logic signed [39:0] st1_prod_in [0:8];

   always_comb begin
      logic signed [23:0] dirv [0:2];
      dirv[0] = $signed(req_tdata[63:40]);
      dirv[1] = $signed(req_tdata[87:64]);
      dirv[2] = $signed(req_tdata[111:88]);
      st1_pxw_in = 52'(req_tdata[19:0]) * 52'(pixel_width_ff);
      st1_pyw_in = 52'(req_tdata[39:20]) * 52'(pixel_height_ff);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            st1_prod_in[3*r+c] = 40'($signed(rot_ff[r][16*c +: 16])) * 40'(dirv[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st1_v_ff <= 1'b0;
      else if (ce) st1_v_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st1_func_ff <= req_tuser;
         st1_pxw_ff  <= st1_pxw_in;
         st1_pyw_ff  <= st1_pyw_in;
         for (int k = 0; k < 9; k++) st1_prod_ff[k] <= st1_prod_in[k];
      end
   end

   // ---------------- stage 2: pixel offset rounding, dot product sums ----------------
   logic               st2_v_ff, st2_func_ff;
   logic [28:0]        st2_mxp_ff, st2_myp_ff, st2_mxp_in, st2_myp_in;
   logic signed [41:0] st2_l_ff [0:2];
   logic signed [41:0] st2_l_in [0:2];

   always_comb begin
      logic signed [52:0] ox, oy;
      logic [52:0]        ax, ay;
      logic [53:0]        rx, ry;
      ox = $signed({1'b0, st1_pxw_ff}) - $signed({10'b0, plane_width_ff, 19'b0});
      oy = $signed({1'b0, st1_pyw_ff}) - $signed({10'b0, plane_height_ff, 19'b0});
      ax = ox[52] ? 53'(-ox) : 53'(ox);
      ay = oy[52] ? 53'(-oy) : 53'(oy);
      // Round half away from zero from Q.40 to Q.16.
      rx = 54'(ax) + (54'(1) << 23);
      ry = 54'(ay) + (54'(1) << 23);
      st2_mxp_in = rx[52:24];
      st2_myp_in = ry[52:24];
      for (int r = 0; r < 3; r++) begin
         st2_l_in[r] = 42'(st1_prod_ff[3*r]) + 42'(st1_prod_ff[3*r+1])
                     + 42'(st1_prod_ff[3*r+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st2_v_ff <= 1'b0;
      else if (ce) st2_v_ff <= st1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st2_func_ff <= st1_func_ff;
         st2_mxp_ff  <= st2_mxp_in;
         st2_myp_ff  <= st2_myp_in;
         for (int r = 0; r < 3; r++) st2_l_ff[r] <= st2_l_in[r];
      end
   end

   // ---------------- stage 3: magnitudes and plane-size products ----------------
   logic        st3_v_ff, st3_func_ff, st3_behind_ff, st3_behind_in;
   logic [28:0] st3_mxp_ff, st3_myp_ff;
   logic [39:0] st3_ax_ff, st3_ay_ff, st3_z_ff, st3_ax_in, st3_ay_in;
   logic [43:0] st3_pwl_ff, st3_pwh_ff, st3_phl_ff, st3_phh_ff;
   logic [43:0] st3_pwl_in, st3_pwh_in, st3_phl_in, st3_phh_in;

   always_comb begin
      logic [41:0] nx, ny;
      nx = 42'(-st2_l_ff[0]);
      ny = 42'(-st2_l_ff[1]);
      st3_ax_in     = st2_l_ff[0][41] ? nx[39:0] : st2_l_ff[0][39:0];
      st3_ay_in     = st2_l_ff[1][41] ? ny[39:0] : st2_l_ff[1][39:0];
      st3_behind_in = st2_l_ff[2][41] || (st2_l_ff[2] == '0);
      st3_pwl_in    = 44'(plane_width_ff)  * 44'(st2_l_ff[2][19:0]);
      st3_pwh_in    = 44'(plane_width_ff)  * 44'(st2_l_ff[2][39:20]);
      st3_phl_in    = 44'(plane_height_ff) * 44'(st2_l_ff[2][19:0]);
      st3_phh_in    = 44'(plane_height_ff) * 44'(st2_l_ff[2][39:20]);
   end

   always_ff @(posedge clock) begin
      if (reset) st3_v_ff <= 1'b0;
      else if (ce) st3_v_ff <= st2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st3_func_ff   <= st2_func_ff;
         st3_mxp_ff    <= st2_mxp_ff;
         st3_myp_ff    <= st2_myp_ff;
         st3_behind_ff <= st3_behind_in;
         st3_ax_ff     <= st3_ax_in;
         st3_ay_ff     <= st3_ay_in;
         st3_z_ff      <= st2_l_ff[2][39:0];
         st3_pwl_ff    <= st3_pwl_in;
         st3_pwh_ff    <= st3_pwh_in;
         st3_phl_ff    <= st3_phl_in;
         st3_phh_ff    <= st3_phh_in;
      end
   end

   // ---------------- stage 4: plane test and divider set-up ----------------
   logic         st4_v_ff;
   div_lane_type st4_x_ff, st4_y_ff, st4_x_in, st4_y_in;
   div_side_type st4_side_ff, st4_side_in;

   always_comb begin
      logic [63:0] pwz, phz;
      logic        out_x, out_y;
      pwz   = 64'(st3_pwl_ff) + (64'(st3_pwh_ff) << 20);
      phz   = 64'(st3_phl_ff) + (64'(st3_phh_ff) << 20);
      // A point exactly on the plane edge is kept.
      out_x = {3'b0, st3_ax_ff, 21'b0} > pwz;
      out_y = {3'b0, st3_ay_ff, 21'b0} > phz;
      // Rounded |x|/z in Q.16: (ax * 2^17 + z) / (2 z).
      st4_x_in.rem = (58'(st3_ax_ff) << 17) + 58'(st3_z_ff);
      st4_x_in.den = {st3_z_ff, 1'b0};
      st4_x_in.quo = '0;
      st4_y_in.rem = (58'(st3_ay_ff) << 17) + 58'(st3_z_ff);
      st4_y_in.den = {st3_z_ff, 1'b0};
      st4_y_in.quo = '0;
      st4_side_in.func     = st3_func_ff;
      st4_side_in.rejected = st3_func_ff && (st3_behind_ff || out_x || out_y);
      st4_side_in.mx_pix   = st3_mxp_ff;
      st4_side_in.my_pix   = st3_myp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) st4_v_ff <= 1'b0;
      else if (ce) st4_v_ff <= st3_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st4_x_ff    <= st4_x_in;
         st4_y_ff    <= st4_y_in;
         st4_side_ff <= st4_side_in;
      end
   end

   // ---------------- projection divider ----------------
   logic         div_v;
   div_lane_type div_x, div_y;
   div_side_type div_side;

   camimp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (st4_v_ff),
      .in_x      (st4_x_ff),
      .in_y      (st4_y_ff),
      .in_side   (st4_side_ff),
      .out_valid (div_v),
      .out_x     (div_x),
      .out_y     (div_y),
      .out_side  (div_side)
   );

   // ---------------- stage 5: squares ----------------
   logic        st5_v_ff, st5_rej_ff;
   logic [57:0] st5_sqx_ff, st5_sqy_ff, st5_sqx_in, st5_sqy_in;

   always_comb begin
      logic [28:0] mx, my;
      mx = div_side.func ? 29'(div_x.quo) : div_side.mx_pix;
      my = div_side.func ? 29'(div_y.quo) : div_side.my_pix;
      st5_sqx_in = 58'(mx) * 58'(mx);
      st5_sqy_in = 58'(my) * 58'(my);
   end

   always_ff @(posedge clock) begin
      if (reset) st5_v_ff <= 1'b0;
      else if (ce) st5_v_ff <= div_v;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st5_rej_ff <= div_side.rejected;
         st5_sqx_ff <= st5_sqx_in;
         st5_sqy_ff <= st5_sqy_in;
      end
   end

   // ---------------- stage 6: q = 1 + x^2 + y^2 in Q.32 ----------------
   logic           st6_v_ff;
   sqrt_stage_type st6_ff, st6_in;

   always_comb begin
      st6_in.q        = (60'(1) << 32) + 60'(st5_sqx_ff) + 60'(st5_sqy_ff);
      st6_in.root     = '0;
      st6_in.rem      = '0;
      st6_in.rejected = st5_rej_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) st6_v_ff <= 1'b0;
      else if (ce) st6_v_ff <= st5_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) st6_ff <= st6_in;
   end

   // ---------------- square root ----------------
   logic           sq_v;
   sqrt_stage_type sq_out;

   camimp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (st6_v_ff),
      .in_data   (st6_ff),
      .out_valid (sq_v),
      .out_data  (sq_out)
   );

   // ---------------- stage 7: q * r partial products ----------------
   logic        st7_v_ff, st7_rej_ff;
   logic [59:0] st7_p0_ff, st7_p1_ff, st7_p0_in, st7_p1_in;

   assign st7_p0_in = 60'(sq_out.q[29:0])  * 60'(sq_out.root);
   assign st7_p1_in = 60'(sq_out.q[59:30]) * 60'(sq_out.root);

   always_ff @(posedge clock) begin
      if (reset) st7_v_ff <= 1'b0;
      else if (ce) st7_v_ff <= sq_v;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st7_rej_ff <= sq_out.rejected;
         st7_p0_ff  <= st7_p0_in;
         st7_p1_ff  <= st7_p1_in;
      end
   end

   // ---------------- stage 8: a = q * r / 2^32 ----------------
   logic        st8_v_ff, st8_rej_ff;
   logic [57:0] st8_a_ff;
   logic [89:0] st8_sum;

   assign st8_sum = 90'(st7_p0_ff) + (90'(st7_p1_ff) << 30);

   always_ff @(posedge clock) begin
      if (reset) st8_v_ff <= 1'b0;
      else if (ce) st8_v_ff <= st7_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st8_rej_ff <= st7_rej_ff;
         st8_a_ff   <= st8_sum[89:32];
      end
   end

   // ---------------- stage 9: a * inv_area partial products ----------------
   logic        st9_v_ff, st9_rej_ff;
   logic [60:0] st9_p0_ff, st9_p1_ff, st9_p0_in, st9_p1_in;

   assign st9_p0_in = 61'(st8_a_ff[28:0])  * 61'(inv_area_ff);
   assign st9_p1_in = 61'(st8_a_ff[57:29]) * 61'(inv_area_ff);

   always_ff @(posedge clock) begin
      if (reset) st9_v_ff <= 1'b0;
      else if (ce) st9_v_ff <= st8_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st9_rej_ff <= st8_rej_ff;
         st9_p0_ff  <= st9_p0_in;
         st9_p1_ff  <= st9_p1_in;
      end
   end

   // ---------------- stage 10: scale, saturate, output register ----------------
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_rej_ff, rsp_sat_ff, rsp_sat_in;
   logic [89:0] st10_sum;

   always_comb begin
      st10_sum = 90'(st9_p0_ff) + (90'(st9_p1_ff) << 29);
      if (st9_rej_ff) begin
         rsp_data_in = '0;
         rsp_sat_in  = 1'b0;
      end else if (|st10_sum[89:48]) begin
         rsp_data_in = '1;
         rsp_sat_in  = 1'b1;
      end else begin
         rsp_data_in = st10_sum[47:16];
         rsp_sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (ce) rsp_v_ff <= st9_v_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_data_ff <= rsp_data_in;
         rsp_rej_ff  <= st9_rej_ff;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_rej_ff};

   // ---------------- assertions ----------------
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("rejected result carries a value or saturation");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '1)
      else $error("saturated result is not the maximum value");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// File: verif/testbench.sv
module testbench
   import camimp_pkg::*;
();

   typedef struct {
      logic        func;
      logic [19:0] pix_x;
      logic [19:0] pix_y;
      logic [23:0] dir_x;
      logic [23:0] dir_y;
      logic [23:0] dir_z;
   } sample_type;

   typedef struct {
      logic [31:0] importance;
      logic        rejected;
      logic        saturated;
   } importance_type;

   localparam int LATENCY   = 60;
   localparam int MAX_CYCLE = 400000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic          req_tuser = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [31:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_we = 0;
   logic [2:0]    csr_addr = '0;
   logic [47:0]   csr_wdata = '0;

   perspective_camera_importance_top u_top (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Camera registers as the predictor sees them.
   logic [47:0] cam_row_x, cam_row_y, cam_row_z;
   logic [23:0] cam_plane_w, cam_plane_h;
   logic [31:0] cam_pix_w, cam_pix_h, cam_inv_area;

   sample_type     pending_samples[$];
   importance_type expected_importance[$];
   int          mismatches = 0;
   int          unexpected = 0;
   int          cycle = 0;
   int          n_sent = 0, n_recv = 0, n_reject = 0, n_sat = 0;
   bit          quiet = 0;   // no idling near the end of the run
   int          send_gap = 0, recv_gap = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic importance_type weigh_offset(input logic [63:0] mx,
                                                   input logic [63:0] my);
      logic [127:0] q, r, a, prod;
      importance_type o;
      q = 128'(64'd1 << 32) + 128'(mx * mx) + 128'(my * my);
      r = 128'(int_sqrt(q[63:0]));
      a = (q * r) >> 32;
      prod = (a * 128'(cam_inv_area)) >> 16;
      o.rejected = 0;
      if (prod > 128'hFFFF_FFFF) begin
         o.importance = '1;
         o.saturated = 1;
      end else begin
         o.importance = prod[31:0];
         o.saturated = 0;
      end
      return o;
   endfunction

   function automatic logic signed [63:0] row_dot(input logic [47:0] row,
                                                  input logic signed [63:0] dx,
                                                  input logic signed [63:0] dy,
                                                  input logic signed [63:0] dz);
      logic signed [63:0] c0, c1, c2;
      c0 = 64'(signed'(row[15:0]));
      c1 = 64'(signed'(row[31:16]));
      c2 = 64'(signed'(row[47:32]));
      return c0 * dx + c1 * dy + c2 * dz;
   endfunction

   function automatic importance_type predict_importance(input sample_type s);
      logic signed [63:0] x40, y40, dx, dy, dz, lx, ly, lz;
      logic [63:0] ax, ay, z, mx, my;
      importance_type rej;
      rej = '{importance: 0, rejected: 1, saturated: 0};
      if (!s.func) begin
         x40 = signed'(64'(s.pix_x) * 64'(cam_pix_w)) - signed'(64'(cam_plane_w) << 19);
         y40 = signed'(64'(s.pix_y) * 64'(cam_pix_h)) - signed'(64'(cam_plane_h) << 19);
         ax = x40 < 0 ? 64'(-x40) : 64'(x40);
         ay = y40 < 0 ? 64'(-y40) : 64'(y40);
         return weigh_offset((ax + (64'd1 << 23)) >> 24, (ay + (64'd1 << 23)) >> 24);
      end
      dx = 64'(signed'(s.dir_x));
      dy = 64'(signed'(s.dir_y));
      dz = 64'(signed'(s.dir_z));
      lx = row_dot(cam_row_x, dx, dy, dz);
      ly = row_dot(cam_row_y, dx, dy, dz);
      lz = row_dot(cam_row_z, dx, dy, dz);
      if (lz <= 0) return rej;
      z = 64'(lz);
      ax = lx < 0 ? 64'(-lx) : 64'(lx);
      ay = ly < 0 ? 64'(-ly) : 64'(ly);
      if ((128'(ax) << 21) > 128'(cam_plane_w) * 128'(z) ||
          (128'(ay) << 21) > 128'(cam_plane_h) * 128'(z))
         return rej;
      mx = ((ax << 17) + z) / (z << 1);
      my = ((ay << 17) + z) / (z << 1);
      return weigh_offset(mx, my);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_importance.push_back(predict_importance(pending_samples.pop_front()));
            n_sent <= n_sent + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(0, 6);
            req_tvalid <= 0;
         end else begin
            // A taken transaction has already left the queue, so the head is next.
            if (pending_samples.size() > 0) begin
               automatic sample_type s = pending_samples[0];
               req_tvalid <= 1;
               req_tuser <= s.func;
               req_tdata <= {s.dir_z, s.dir_y, s.dir_x, s.pix_y, s.pix_x};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_recv <= n_recv + 1;
            if (expected_importance.size() == 0) begin
               unexpected++;
               if (mismatches + unexpected <= 10)
                  $display("unexpected response %h/%b", rsp_tdata, rsp_tuser);
            end else begin
               automatic importance_type e = expected_importance.pop_front();
               if (e.rejected) n_reject <= n_reject + 1;
               if (e.saturated) n_sat <= n_sat + 1;
               if (rsp_tdata !== e.importance || rsp_tuser[0] !== e.rejected ||
                   rsp_tuser[1] !== e.saturated) begin
                  mismatches++;
                  if (mismatches + unexpected <= 10)
                     $display("mismatch: expected %h rej %b sat %b, got %h rej %b sat %b",
                              e.importance, e.rejected, e.saturated,
                              rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(0, 6);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle >= MAX_CYCLE) begin
         $display("timeout at cycle %0d", cycle);
         $display("testbench failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ROT_ROW_X:    cam_row_x = val;
         CSR_ROT_ROW_Y:    cam_row_y = val;
         CSR_ROT_ROW_Z:    cam_row_z = val;
         CSR_PLANE_WIDTH:  cam_plane_w = val[23:0];
         CSR_PLANE_HEIGHT: cam_plane_h = val[23:0];
         CSR_PIXEL_WIDTH:  cam_pix_w = val[31:0];
         CSR_PIXEL_HEIGHT: cam_pix_h = val[31:0];
         CSR_INV_AREA:     cam_inv_area = val[31:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_importance.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [47:0] coeff_row(input logic [15:0] cx, input logic [15:0] cy,
                                            input logic [15:0] cz);
      return {cz, cy, cx};
   endfunction

   // Random sample; kind 2 gives a direction that mostly lands on the plane for the current setting.
   function automatic sample_type rand_sample(input int kind);
      sample_type s;
      s.func = 1'($urandom_range(0, 1));
      s.pix_x = 20'($urandom);
      s.pix_y = 20'($urandom);
      s.dir_x = 24'($urandom);
      s.dir_y = 24'($urandom);
      s.dir_z = 24'($urandom);
      if (kind == 1) begin
         s.pix_x = 20'($urandom_range(0, 2048 * 256));
         s.pix_y = 20'($urandom_range(0, 2048 * 256));
      end else if (kind == 2) begin
         s.dir_z = 24'($urandom_range(1000, 8388607));
         s.dir_x = 24'(signed'($urandom_range(0, 2000000)) - 1000000);
         s.dir_y = 24'(signed'($urandom_range(0, 2000000)) - 1000000);
         if ($urandom_range(0, 3) == 0) begin
            s.dir_x = 24'(signed'($urandom_range(0, 200)) - 100);
            s.dir_y = 24'(signed'($urandom_range(0, 200)) - 100);
            s.dir_z = 24'($urandom_range(1, 300));
         end
      end
      return s;
   endfunction

   initial begin
      cam_row_x = ROT_ROW_X_RESET;
      cam_row_y = ROT_ROW_Y_RESET;
      cam_row_z = ROT_ROW_Z_RESET;
      cam_plane_w = 0; cam_plane_h = 0;
      cam_pix_w = 0; cam_pix_h = 0; cam_inv_area = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed part: reset registers first, then a typical 90 degree camera.
      pending_samples.push_back('{0, 0, 0, 0, 0, 0});
      pending_samples.push_back('{1, 0, 0, 0, 0, 24'd100});
      pending_samples.push_back('{1, 0, 0, 24'd1, 0, 24'd100});
      pending_samples.push_back('{1, 0, 0, 0, 0, 0});
      wait_drained();
      write_reg(CSR_PLANE_WIDTH, 48'h20_0000);    // 2.0: edge at |x| = z
      write_reg(CSR_PLANE_HEIGHT, 48'h18_0000);   // 1.5
      write_reg(CSR_PIXEL_WIDTH, 48'h0080_0000);
      write_reg(CSR_PIXEL_HEIGHT, 48'h0060_0000);
      write_reg(CSR_INV_AREA, 48'h0000_AAAB);
      pending_samples.push_back('{0, 20'hFFFFF, 20'hFFFFF, 24'h800000, 24'h7FFFFF, 0});
      pending_samples.push_back('{0, 20'd0, 20'hFFFFF, 0, 0, 0});
      pending_samples.push_back('{0, 20'h02000, 20'h02000, 0, 0, 0});
      pending_samples.push_back('{1, 20'hFFFFF, 0, 24'd100, 0, 24'd100});   // on the edge
      pending_samples.push_back('{1, 0, 0, 24'd101, 0, 24'd100});           // just outside
      pending_samples.push_back('{1, 0, 0, 24'hFFFF9C, 24'hFFFFB5, 24'd100});
      pending_samples.push_back('{1, 0, 0, 24'd0, 24'd75, 24'd100});
      pending_samples.push_back('{1, 0, 0, 0, 0, 24'h800000});              // behind
      pending_samples.push_back('{1, 0, 0, 24'h800000, 24'h800000, 24'h7FFFFF});
      pending_samples.push_back('{1, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
      pending_samples.push_back('{1, 0, 0, 0, 0, 24'h7FFFFF});
      wait_drained();
      write_reg(CSR_INV_AREA, 48'hFFFF_FFFF);   // forces saturation
      write_reg(CSR_ROT_ROW_X, coeff_row(16'h7FFF, 16'h8000, 16'hFFFF));
      write_reg(CSR_ROT_ROW_Y, coeff_row(16'h8000, 16'h7FFF, 16'h0001));
      write_reg(CSR_ROT_ROW_Z, coeff_row(16'h0001, 16'hFFFF, 16'h7FFF));
      write_reg(CSR_PLANE_WIDTH, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_PLANE_HEIGHT, 48'hFFFFFF);
      write_reg(CSR_PIXEL_WIDTH, 48'hFFFF_FFFF);
      write_reg(CSR_PIXEL_HEIGHT, 48'hFFFF_FFFF);
      pending_samples.push_back('{0, 20'hFFFFF, 20'hFFFFF, 0, 0, 0});
      pending_samples.push_back('{0, 0, 0, 0, 0, 0});
      pending_samples.push_back('{1, 0, 0, 24'd5, 24'd3, 24'd1000});
      pending_samples.push_back('{1, 0, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF});
      wait_drained();

      // Random phases over several register settings.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) begin
            write_reg(CSR_ROT_ROW_X, ROT_ROW_X_RESET);
            write_reg(CSR_ROT_ROW_Y, ROT_ROW_Y_RESET);
            write_reg(CSR_ROT_ROW_Z, ROT_ROW_Z_RESET);
            write_reg(CSR_INV_AREA, 48'h0000_AAAB);
         end else begin
            // rotation with coefficients of modest size keeps z mostly positive; phase 5 takes a random z row
            write_reg(CSR_ROT_ROW_X, coeff_row(16'($urandom_range(0, 8192) - 4096),
                                               16'($urandom_range(0, 2048) - 1024),
                                               16'($urandom_range(0, 2048) - 1024)));
            write_reg(CSR_ROT_ROW_Y, coeff_row(16'($urandom_range(0, 2048) - 1024),
                                               16'($urandom_range(0, 8192) - 4096),
                                               16'($urandom_range(0, 2048) - 1024)));
            write_reg(CSR_ROT_ROW_Z, (phase == 5) ? 48'($urandom) << 16 | 48'($urandom) :
                      coeff_row(16'($urandom_range(0, 1024) - 512),
                                16'($urandom_range(0, 1024) - 512),
                                16'($urandom_range(2048, 32767))));
            write_reg(CSR_INV_AREA, (phase == 4) ? 48'($urandom) : 48'($urandom_range(0, 200000)));
         end
         write_reg(CSR_PLANE_WIDTH, phase == 3 ? 48'd0 : 48'($urandom_range(1 << 18, 1 << 23)));
         write_reg(CSR_PLANE_HEIGHT, phase == 3 ? 48'hFFFFFF :
                   48'($urandom_range(1 << 18, 1 << 23)));
         write_reg(CSR_PIXEL_WIDTH, phase == 4 ? 48'hFFFF_FFFF : 48'($urandom_range(0, 1 << 22)));
         write_reg(CSR_PIXEL_HEIGHT, 48'($urandom));
         quiet = (phase == 5);
         repeat (325) begin
            automatic int r = $urandom_range(0, 9);
            pending_samples.push_back(rand_sample(r < 2 ? 0 : (r < 5 ? 1 : 2)));
         end
         wait_drained();
      end

      $display("sent %0d requests, checked %0d responses (%0d rejected, %0d saturated)",
               n_sent, n_recv, n_reject, n_sat);
      if (mismatches == 0 && unexpected == 0 && expected_importance.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
